### rtl/varint_length_prefixed_deframer_core_defines.svh
// Assertion macros shared by the deframer modules.
`ifndef VARINT_LENGTH_PREFIXED_DEFRAMER_CORE_DEFINES_SVH
`define VARINT_LENGTH_PREFIXED_DEFRAMER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define VLPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define VLPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### rtl/vlpd_pkg.sv
package vlpd_pkg;

    // Field widths
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 32;
    localparam int unsigned REM_W      = 31;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned GROUP_W    = 3;
    localparam int unsigned POS_W      = 6;

    // Varint format
    localparam int unsigned GROUP_BITS = 7;
    localparam int unsigned MAX_GROUPS = 5;

    // Reset value of the maximum frame length register
    localparam logic [REM_W-1:0] MAX_LEN_RST = 31'd2097151;

    // Default depth of the result queue
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        ST_PAYLOAD  = 2'd0,
        ST_TOO_BIG  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              last_of_frame;
        t_status           status;
        logic [CNT_W-1:0]  frames_seen;
    } t_result;

endpackage

### rtl/vlpd_front.sv
`include "varint_length_prefixed_deframer_core_defines.svh"

module vlpd_front
    import vlpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_cfg_we,
    input  logic [REM_W-1:0]  i_cfg_wdata,
    output logic              o_wr,
    output t_result           o_result
);

    typedef enum logic [1:0] {
        PH_LENGTH  = 2'b01,
        PH_PAYLOAD = 2'b10
    } t_phase;

    t_phase             r_phase,     n_phase;
    logic [LEN_W-1:0]   r_len_acc,   n_len_acc;
    logic [GROUP_W-1:0] r_group,     n_group;
    logic [REM_W-1:0]   r_remaining, n_remaining;
    logic [CNT_W-1:0]   r_frames,    n_frames;
    logic [REM_W-1:0]   r_max_len;

    logic [POS_W-1:0]   w_pos;
    logic [LEN_W-1:0]   w_acc_new;

    // Merge the low seven bits of the byte into the length at its group position
    assign w_pos     = POS_W'(r_group) * POS_W'(GROUP_BITS);
    assign w_acc_new = r_len_acc | (LEN_W'(i_byte[GROUP_BITS-1:0]) << w_pos);

    // Classify the accepted byte and build the result word
    always_comb begin
        n_phase     = r_phase;
        n_len_acc   = r_len_acc;
        n_group     = r_group;
        n_remaining = r_remaining;
        n_frames    = r_frames;
        o_wr        = 1'b0;
        o_result    = '{payload_byte: '0, last_of_frame: 1'b0,
                        status: ST_PAYLOAD, frames_seen: r_frames};
        if (i_accept) begin
            unique case (r_phase)
                PH_PAYLOAD: begin
                    o_wr                  = 1'b1;
                    o_result.payload_byte = i_byte;
                    if (r_remaining <= REM_W'(1)) begin
                        // final byte: count the frame, go back to the length
                        n_frames               = r_frames + CNT_W'(1);
                        o_result.last_of_frame = 1'b1;
                        o_result.frames_seen   = n_frames;
                        n_remaining            = '0;
                        n_phase                = PH_LENGTH;
                        n_len_acc              = '0;
                        n_group                = '0;
                    end else begin
                        n_remaining = r_remaining - REM_W'(1);
                    end
                end
                PH_LENGTH: begin
                    if (!i_byte[BYTE_W-1]) begin
                        // length complete: check it and start the payload if it is nonzero and in range
                        n_len_acc = '0;
                        n_group   = '0;
                        if (w_acc_new == '0) begin
                            o_wr            = 1'b1;
                            o_result.status = ST_EMPTY;
                        end else if (w_acc_new > LEN_W'(r_max_len)) begin
                            o_wr            = 1'b1;
                            o_result.status = ST_TOO_LONG;
                        end else begin
                            n_remaining = w_acc_new[REM_W-1:0];
                            n_phase     = PH_PAYLOAD;
                        end
                    end else if (r_group == GROUP_W'(MAX_GROUPS - 1)) begin
                        // continuation on the last group: drop the length
                        n_len_acc       = '0;
                        n_group         = '0;
                        o_wr            = 1'b1;
                        o_result.status = ST_TOO_BIG;
                    end else begin
                        n_len_acc = w_acc_new;
                        n_group   = r_group + GROUP_W'(1);
                    end
                end
                default: begin
                    n_phase   = PH_LENGTH;
                    n_len_acc = '0;
                    n_group   = '0;
                end
            endcase
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LENGTH;
            r_len_acc   <= '0;
            r_group     <= '0;
            r_remaining <= '0;
            r_frames    <= '0;
            r_max_len   <= MAX_LEN_RST;
        end else begin
            r_phase     <= n_phase;
            r_len_acc   <= n_len_acc;
            r_group     <= n_group;
            r_remaining <= n_remaining;
            r_frames    <= n_frames;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
        end
    end

    `VLPD_ASSERT(a_group_bound, r_group <= GROUP_W'(MAX_GROUPS - 1), "group index past fifth group")
    `VLPD_ASSERT(a_payload_nonzero, (r_phase == PH_PAYLOAD) |-> (r_remaining != '0), "payload phase with no bytes left")

endmodule

### rtl/vlpd_queue.sv
`include "varint_length_prefixed_deframer_core_defines.svh"

module vlpd_queue
    import vlpd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_data,
    input  logic    i_rd,
    output logic    o_full,
    output logic    o_empty,
    output t_result o_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_result         r_slot [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign w_push  = i_wr && !o_full;
    assign w_pop   = i_rd && !o_empty;

    // Advance the pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `VLPD_ASSERT(a_count_bound, r_count <= CW'(DEPTH), "queue count above depth")
    `VLPD_ASSERT(a_count_up, (w_push && !w_pop) |=> (r_count == $past(r_count) + CW'(1)), "queue count did not rise on push")

endmodule

### rtl/varint_length_prefixed_deframer_core.sv
// Length-prefixed byte-stream deframer. Each frame opens with a little-endian
// base-128 varint length of up to five bytes, followed by that many payload
// bytes, which come out one word each with last_of_frame on the final one and
// the running frame count. A zero length gives an empty-frame word, a length
// with a continuation bit on its fifth byte a too-big word, and a length above
// max_frame_length a too-long word; after any of these the next byte starts a
// new length. Length bytes that do not end in an error give no word. One byte
// is taken every cycle: the parser settles each byte combinationally and
// writes its word into a P_QUEUE_DEPTH-entry result queue, so input stalls only
// when that queue is full. A result can be popped the cycle after its byte is
// pushed. Write max_frame_length only while the deframer is idle.
module varint_length_prefixed_deframer_core
    import vlpd_pkg::*;
#(
    parameter int unsigned P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_cfg_we,
    input  logic [REM_W-1:0]  i_cfg_wdata,
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic              o_last_of_frame,
    output logic [1:0]        o_status,
    output logic [CNT_W-1:0]  o_frames_seen
);

    logic    w_accept;
    logic    w_wr;
    t_result w_front_res;
    t_result w_head;

    assign w_accept = push && !full;

    // Parse bytes into result words
    vlpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (i_in_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_wr        (w_wr),
        .o_result    (w_front_res)
    );

    // Buffer result words for the consumer
    vlpd_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_data  (w_front_res),
        .i_rd    (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (w_head)
    );

    assign o_payload_byte  = w_head.payload_byte;
    assign o_last_of_frame = w_head.last_of_frame;
    assign o_status        = w_head.status;
    assign o_frames_seen   = w_head.frames_seen;

endmodule
